/* sv/spf_pkg.sv */
// Shared types and constants of the sequenced packet framer.
`default_nettype none

package spf_pkg;

   // Fixed frame constants
   localparam logic [7:0]  START_BYTE   = 8'hAA;
   localparam logic [7:0]  CHECK_FORCED = 8'h00;
   localparam logic [8:0]  LEN_OVERHEAD = 9'd4;
   localparam logic [31:0] SEQ_RESET    = 32'd1;

   // Position of the emitted byte within the frame of one payload byte
   typedef enum logic [3:0] {
      STEP_START,
      STEP_ID,
      STEP_LEN_HI,
      STEP_LEN_LO,
      STEP_SEQ3,
      STEP_SEQ2,
      STEP_SEQ1,
      STEP_SEQ0,
      STEP_DATA,
      STEP_CHECK
   } step_type;

   // One input transaction as held by the emitter
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] packet_id;
      logic [7:0] payload_length;
      logic       is_first;
      logic       is_last;
      logic       corrupt_checksum;
   } item_type;

   // One byte of the framed stream
   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_packet;
   } frame_byte_type;

   // Emitter status seen by the top level
   typedef struct packed {
      logic     busy;
      logic     last_step;
      step_type step;
   } emit_status_type;

endpackage

`default_nettype wire

/* sv/spf_if.sv */
// Handshake interfaces of the request and response channels.
`default_nettype none

interface spf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [7:0] packet_id;
   logic [7:0] payload_length;
   logic       is_first;
   logic       is_last;
   logic       corrupt_checksum;

   modport source (
      output valid, data_byte, packet_id, payload_length, is_first, is_last,
             corrupt_checksum,
      input  ready
   );
   modport sink (
      input  valid, data_byte, packet_id, payload_length, is_first, is_last,
             corrupt_checksum,
      output ready
   );
endinterface

interface spf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_packet;

   modport source (
      output valid, out_byte, end_of_packet,
      input  ready
   );
   modport sink (
      input  valid, out_byte, end_of_packet,
      output ready
   );
endinterface

`default_nettype wire

/* sv/spf_emit.sv */
// Byte sequencer: holds one payload transaction and emits its frame bytes.
`default_nettype none

module spf_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   spf_req_if.sink                      req_bus,
   output logic                         byte_valid,
   output spf_pkg::frame_byte_type      byte_data,
   input  wire logic                    byte_ready,
   output spf_pkg::emit_status_type     status
);
   import spf_pkg::*;

   item_type   item_ff,  item_in;
   logic       busy_ff,  busy_in;
   step_type   step_ff,  step_in;
   logic [31:0] seq_ff,  seq_in;
   logic [7:0] sum_ff,   sum_in;

   logic       last_step;
   logic       advance;
   logic       accept;
   logic [8:0] len_full;
   logic [7:0] cur_byte;

   // Final byte of the held transaction
   assign last_step = (step_ff == STEP_CHECK) ||
                      ((step_ff == STEP_DATA) && !item_ff.is_last);
   assign advance   = busy_ff && byte_ready;
   assign req_bus.ready = !busy_ff || (advance && last_step);
   assign accept    = req_bus.valid && req_bus.ready;

   // Header length is payload length plus the sequence field
   assign len_full = {1'b0, item_ff.payload_length} + LEN_OVERHEAD;

   // Select the byte for the current step
   always_comb begin
      cur_byte = item_ff.data_byte;
      unique case (step_ff)
         STEP_START:  cur_byte = START_BYTE;
         STEP_ID:     cur_byte = item_ff.packet_id;
         STEP_LEN_HI: cur_byte = {7'd0, len_full[8]};
         STEP_LEN_LO: cur_byte = len_full[7:0];
         STEP_SEQ3:   cur_byte = seq_ff[31:24];
         STEP_SEQ2:   cur_byte = seq_ff[23:16];
         STEP_SEQ1:   cur_byte = seq_ff[15:8];
         STEP_SEQ0:   cur_byte = seq_ff[7:0];
         STEP_DATA:   cur_byte = item_ff.data_byte;
         STEP_CHECK:  cur_byte = item_ff.corrupt_checksum ? CHECK_FORCED : sum_ff;
         default:     cur_byte = item_ff.data_byte;
      endcase
   end

   assign byte_valid              = busy_ff;
   assign byte_data.out_byte      = cur_byte;
   assign byte_data.end_of_packet = (step_ff == STEP_CHECK);

   assign status.busy      = busy_ff;
   assign status.last_step = last_step;
   assign status.step      = step_ff;

   // Load a new transaction or step through the current frame
   always_comb begin
      item_in = item_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      seq_in  = seq_ff;
      sum_in  = sum_ff;

      // Accumulate the checksum over sequence and payload bytes
      if (advance) begin
         case (step_ff) inside
            STEP_SEQ3:  sum_in = cur_byte;
            STEP_SEQ2,
            STEP_SEQ1,
            STEP_SEQ0,
            STEP_DATA:  sum_in = sum_ff + cur_byte;
            STEP_CHECK: begin
               sum_in = 8'd0;
               seq_in = seq_ff + 32'd1;
            end
            default:    sum_in = sum_ff;
         endcase
         if (last_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_type'(step_ff + 4'd1);
         end
      end

      if (accept) begin
         item_in.data_byte        = req_bus.data_byte;
         item_in.packet_id        = req_bus.packet_id;
         item_in.payload_length   = req_bus.payload_length;
         item_in.is_first         = req_bus.is_first;
         item_in.is_last          = req_bus.is_last;
         item_in.corrupt_checksum = req_bus.corrupt_checksum;
         busy_in = 1'b1;
         step_in = req_bus.is_first ? STEP_START : STEP_DATA;
      end
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_DATA;
         seq_ff  <= SEQ_RESET;
         sum_ff  <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         seq_ff  <= seq_in;
         sum_ff  <= sum_in;
      end
   end

   // Hold the transaction payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

/* sv/spf_out_reg.sv */
// Output register between the sequencer and the response channel.
`default_nettype none

module spf_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    byte_valid,
   input  spf_pkg::frame_byte_type      byte_data,
   output logic                         byte_ready,
   spf_rsp_if.source                    rsp_bus
);
   import spf_pkg::*;

   logic           valid_ff, valid_in;
   frame_byte_type data_ff,  data_in;
   logic           load;

   // Take a new byte when the register is empty or being drained
   assign byte_ready = !valid_ff || rsp_bus.ready;
   assign load       = byte_valid && byte_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = byte_data;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.out_byte      = data_ff.out_byte;
   assign rsp_bus.end_of_packet = data_ff.end_of_packet;

endmodule

`default_nettype wire

/* sv/sequenced_packet_framer.sv */
// Top level of the sequenced packet framer.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+---------------------------------------
//   req_bus   | in  | valid/ready        | data_byte, packet_id, payload_length,
//             |     |                    | is_first, is_last, corrupt_checksum
//   rsp_bus   | out | valid/ready        | out_byte, end_of_packet
//
// One framed byte leaves per cycle while rsp_bus does not stall; a transaction emits one
// byte for a middle byte, nine with is_first, two with is_last and ten with both, set by the
// byte sequencer. Middle bytes flow one per cycle while rsp_bus does not stall.
// Synchronous reset sets the sequence number to 1 and clears the checksum.
// A stall on rsp_bus holds the output register and the sequencer in place.
`default_nettype none

module sequenced_packet_framer (
   input  wire logic clock,
   input  wire logic reset,
   spf_req_if.sink   req_bus,
   spf_rsp_if.source rsp_bus
);
   import spf_pkg::*;

   logic            byte_valid;
   logic            byte_ready;
   frame_byte_type  byte_data;
   emit_status_type status;

   spf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .byte_ready (byte_ready),
      .status     (status)
   );

   spf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .byte_ready (byte_ready),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTHESIS
   // Accept only when the sequencer is free or finishing its frame
   assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!status.busy || status.last_step))
      else $error("request taken while frame still in progress");

   // A first byte starts the frame at the start byte
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.is_first) |=>
         (status.busy && status.step == STEP_START))
      else $error("first byte did not open a header");

   // Two checksum bytes never follow each other
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.end_of_packet) |=>
         !(rsp_bus.valid && rsp_bus.end_of_packet))
      else $error("back-to-back checksum bytes");
`endif

endmodule

`default_nettype wire
